// ===== rtl/core/stpt_pkg.sv =====
// Shared types, constants and helpers for the stepper position tracker.
`timescale 1ns / 1ps

package stpt_pkg;

    localparam int POSITION_FRAC_BITS = 8;
    localparam int SPEED_WIDTH        = 24;

    localparam int POS_W   = 32;
    localparam int LIM_W   = 23;
    localparam int ACC_W   = LIM_W - 6;
    localparam int CFG_DW  = 23;
    localparam int CFG_IW  = 2;

    // shared multiplier: limit, error or speed (33b signed) by reciprocal or gain (25b signed)
    localparam int MUL_AW  = 33;
    localparam int MUL_BW  = 25;
    localparam int PROD_W  = MUL_AW + MUL_BW;

    // lim / 100 as (lim * RECIP_100) >> RECIP_SHIFT, exact for lim < 2^23
    localparam int RECIP_SHIFT = 30;
    localparam logic [23:0] RECIP_100 = 24'd10737419;

    localparam int RND_SH = 16 - POSITION_FRAC_BITS;

    localparam logic signed [SPEED_WIDTH-1:0] SPD_MAX =
        {1'b0, {(SPEED_WIDTH-1){1'b1}}};

    typedef enum logic [2:0] {
        ACT_SET_SPEED  = 3'd0,
        ACT_STOP       = 3'd1,
        ACT_SET_TARGET = 3'd2,
        ACT_JOG        = 3'd3,
        ACT_ZERO       = 3'd4,
        ACT_TICK       = 3'd5
    } t_action;

    typedef enum logic [CFG_IW-1:0] {
        CFG_KP_GAIN    = 2'd0,
        CFG_POS_GAIN   = 2'd1,
        CFG_ARRIVE_TOL = 2'd2,
        CFG_STALL_MIN  = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CMD,
        ST_ERR,
        ST_ACC,
        ST_WANT,
        ST_CLAMP,
        ST_SLEW,
        ST_SNAP,
        ST_STALL,
        ST_ROUND,
        ST_MOVE,
        ST_DIFF,
        ST_ARRIVE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]              action;
        logic signed [POS_W-1:0] command_value;
        logic [LIM_W-1:0]        tracking_limit;
        logic [9:0]              stall_reading;
    } t_in_item;

    typedef struct packed {
        logic signed [SPEED_WIDTH-1:0] drive_speed;
        logic signed [POS_W-1:0]       position_now;
        logic signed [POS_W-1:0]       target_now;
        logic                          moving;
        logic                          stall_seen;
        logic                          arrived;
        logic                          save_request;
    } t_out_item;

    typedef struct packed {
        logic [7:0]       kp_gain;
        logic [15:0]      position_gain;
        logic [15:0]      arrive_tolerance;
        logic [LIM_W-1:0] stall_min_speed;
    } t_cfg;

    typedef struct packed {
        logic                     en;
        logic signed [MUL_AW-1:0] a;
        logic signed [MUL_BW-1:0] b;
    } t_mul_op;

    // saturate a widened position sum to the 32-bit range
    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [34:0] v);
        logic signed [34:0]     hi;
        logic signed [34:0]     lo;
        logic signed [POS_W-1:0] res;
        hi = 35'sh0_7FFF_FFFF;
        lo = 35'sh7_8000_0000;
        if (v > hi) begin
            res = hi[POS_W-1:0];
        end else if (v < lo) begin
            res = lo[POS_W-1:0];
        end else begin
            res = v[POS_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/stpt_cfg.sv =====
// Configuration register file: gains, tolerance and stall threshold.
`timescale 1ns / 1ps

module stpt_cfg
    import stpt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_we,
    input  logic [CFG_IW-1:0] i_index,
    input  logic [CFG_DW-1:0] i_data,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp_gain          <= 8'd5;
            r_cfg.position_gain    <= 16'd469;
            r_cfg.arrive_tolerance <= 16'd512;
            r_cfg.stall_min_speed  <= LIM_W'(100);
        end else if (i_we) begin
            case (i_index)
                CFG_KP_GAIN:    r_cfg.kp_gain          <= i_data[7:0];
                CFG_POS_GAIN:   r_cfg.position_gain    <= i_data[15:0];
                CFG_ARRIVE_TOL: r_cfg.arrive_tolerance <= i_data[15:0];
                CFG_STALL_MIN:  r_cfg.stall_min_speed  <= i_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/stpt_mul.sv =====
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps

module stpt_mul
    import stpt_pkg::*;
(
    input  logic                     i_clk,
    input  t_mul_op                  i_op,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_op.en) begin
            r_prod <= PROD_W'(i_op.a) * PROD_W'(i_op.b);
        end
    end

    assign o_prod = r_prod;

endmodule

// ===== rtl/core/stpt_ctrl.sv =====
// Sequencer and axis state: commands, tracking law, stall, integration, arrival.
`timescale 1ns / 1ps

module stpt_ctrl
    import stpt_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  t_in_item                 i_item,
    input  t_cfg                     i_cfg,
    input  logic signed [PROD_W-1:0] i_prod,
    input  logic                     i_res_take,
    output logic                     o_idle,
    output t_mul_op                  o_mul_op,
    output logic                     o_res_valid,
    output t_out_item                o_res
);

    localparam int SW = SPEED_WIDTH;
    localparam logic signed [PROD_W-1:0] TRUNC_BIAS =
        PROD_W'((1 << POSITION_FRAC_BITS) - 1);
    localparam logic [PROD_W-1:0] RND_HALF =
        (RND_SH == 0) ? '0 : PROD_W'(1 << ((RND_SH == 0) ? 0 : RND_SH - 1));
    localparam logic [PROD_W-1:0] RND_HALF_P1 = RND_HALF + PROD_W'(1);
    localparam logic signed [32:0] SAVE_TH = 33'((1 << POSITION_FRAC_BITS) / 10);
    localparam logic signed [32:0] SPD_HI33 = {{(33-SW){1'b0}}, SPD_MAX};
    localparam logic signed [32:0] SPD_LO33 = -SPD_HI33;
    localparam logic signed [SW-1:0] SPD_TEN = SW'(10);
    localparam logic [ACC_W-1:0] ACC_MIN = ACC_W'(10);

    t_state r_state;
    t_state n_state;

    t_in_item                 r_item;
    logic signed [POS_W-1:0]  r_pos;
    logic signed [POS_W-1:0]  r_goal;
    logic signed [POS_W-1:0]  r_saved;
    logic signed [SW-1:0]     r_speed;
    logic signed [SW-1:0]     r_last;
    logic                     r_track;
    logic [LIM_W-1:0]         r_limit;
    logic signed [32:0]       r_err;
    logic [32:0]              r_err_mag;
    logic [ACC_W-1:0]         r_acc;
    logic signed [33:0]       r_want;
    logic [33:0]              r_q;
    logic                     r_q_neg;
    logic                     r_stalled;
    logic                     r_arr;
    logic                     r_save;

    // combinational helpers
    logic signed [33:0]       lim_s;
    logic signed [33:0]       acc_s;
    logic signed [33:0]       spd34;
    logic signed [33:0]       slew_up;
    logic signed [33:0]       slew_dn;
    logic signed [32:0]       spd33;
    logic signed [32:0]       min33;
    logic signed [32:0]       val33;
    logic signed [32:0]       lim33;
    logic signed [34:0]       jog_sum;
    logic signed [POS_W-1:0]  jog_base;
    logic signed [PROD_W-1:0] trunc_sum;
    logic [PROD_W-1:0]        rnd_mag;
    logic [ACC_W-1:0]         quot;
    logic signed [34:0]       pos35;
    logic signed [34:0]       step35;
    logic signed [34:0]       move_sum;

    assign lim_s    = $signed({11'b0, r_limit});
    assign acc_s    = $signed({{(34-ACC_W){1'b0}}, r_acc});
    assign spd34    = {{(34-SW){r_speed[SW-1]}}, r_speed};
    assign slew_up  = spd34 + acc_s;
    assign slew_dn  = spd34 - acc_s;
    assign spd33    = {{(33-SW){r_speed[SW-1]}}, r_speed};
    assign min33    = $signed({10'b0, i_cfg.stall_min_speed});
    assign val33    = {r_item.command_value[POS_W-1], r_item.command_value};
    assign lim33    = $signed({10'b0, r_item.tracking_limit});
    assign jog_base = r_track ? r_goal : r_pos;
    assign jog_sum  = {{3{jog_base[POS_W-1]}}, jog_base}
                    + {{3{r_item.command_value[POS_W-1]}}, r_item.command_value};
    assign trunc_sum = i_prod + (i_prod[PROD_W-1] ? TRUNC_BIAS : '0);
    assign rnd_mag  = i_prod[PROD_W-1] ? ($unsigned(~i_prod) + RND_HALF_P1)
                                       : ($unsigned(i_prod) + RND_HALF);
    assign quot     = i_prod[RECIP_SHIFT +: ACC_W];
    assign pos35    = {{3{r_pos[POS_W-1]}}, r_pos};
    assign step35   = $signed({1'b0, r_q});
    assign move_sum = r_q_neg ? (pos35 - step35) : (pos35 + step35);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_mul_op   = '0;
        o_idle     = 1'b0;
        o_res_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_idle = 1'b1;
                if (i_start) begin
                    if (i_item.action != ACT_TICK) begin
                        n_state = ST_CMD;
                    end else if (r_track) begin
                        n_state = ST_ERR;
                    end else begin
                        n_state = ST_STALL;
                    end
                end
            end
            ST_CMD:  n_state = ST_DONE;
            ST_ERR: begin
                o_mul_op.en = 1'b1;
                o_mul_op.a  = $signed({10'b0, r_limit});
                o_mul_op.b  = $signed({1'b0, RECIP_100});
                n_state = ST_ACC;
            end
            ST_ACC: begin
                o_mul_op.en = 1'b1;
                o_mul_op.a  = r_err;
                o_mul_op.b  = $signed({17'b0, i_cfg.kp_gain});
                n_state = ST_WANT;
            end
            ST_WANT:  n_state = ST_CLAMP;
            ST_CLAMP: n_state = ST_SLEW;
            ST_SLEW:  n_state = ST_SNAP;
            ST_SNAP:  n_state = ST_STALL;
            ST_STALL: begin
                // product is only used when the speed survives the stall check
                o_mul_op.en = 1'b1;
                o_mul_op.a  = spd33;
                o_mul_op.b  = $signed({9'b0, i_cfg.position_gain});
                n_state = ST_ROUND;
            end
            ST_ROUND:  n_state = ST_MOVE;
            ST_MOVE:   n_state = ST_DIFF;
            ST_DIFF:   n_state = ST_ARRIVE;
            ST_ARRIVE: n_state = ST_DONE;
            ST_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // axis state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_goal    <= '0;
            r_saved   <= '0;
            r_speed   <= '0;
            r_last    <= '0;
            r_track   <= 1'b0;
            r_limit   <= '0;
            r_stalled <= 1'b0;
            r_arr     <= 1'b0;
            r_save    <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_stalled <= 1'b0;
                        r_arr     <= 1'b0;
                        r_save    <= 1'b0;
                    end
                end
                ST_CMD: begin
                    case (r_item.action)
                        ACT_SET_SPEED: begin
                            if (val33 > SPD_HI33) begin
                                r_speed <= SPD_HI33[SW-1:0];
                            end else if (val33 < SPD_LO33) begin
                                r_speed <= SPD_LO33[SW-1:0];
                            end else begin
                                r_speed <= val33[SW-1:0];
                            end
                            r_track <= 1'b0;
                        end
                        ACT_STOP: r_speed <= '0;
                        ACT_SET_TARGET: begin
                            r_goal  <= r_item.command_value;
                            r_limit <= (lim33 > SPD_HI33) ? SPD_HI33[LIM_W-1:0]
                                                          : r_item.tracking_limit;
                            r_track <= 1'b1;
                        end
                        ACT_JOG: begin
                            r_goal  <= sat_pos(jog_sum);
                            r_track <= 1'b1;
                        end
                        ACT_ZERO: r_pos <= '0;
                        default: ;
                    endcase
                end
                ST_SLEW: begin
                    if (r_want > slew_up) begin
                        r_speed <= slew_up[SW-1:0];
                    end else if (r_want < slew_dn) begin
                        r_speed <= slew_dn[SW-1:0];
                    end else begin
                        r_speed <= r_want[SW-1:0];
                    end
                end
                ST_SNAP: begin
                    if (r_err_mag < {17'b0, i_cfg.arrive_tolerance}
                        && r_speed <= SPD_TEN && r_speed >= -SPD_TEN) begin
                        r_pos   <= r_goal;
                        r_speed <= '0;
                        r_track <= 1'b0;
                    end
                end
                ST_STALL: begin
                    if (r_speed != '0 && r_item.stall_reading == '0
                        && (spd33 > min33 || spd33 < -min33)) begin
                        r_speed   <= '0;
                        r_track   <= 1'b0;
                        r_stalled <= 1'b1;
                    end
                end
                ST_MOVE: begin
                    if (r_speed != '0) begin
                        r_pos <= sat_pos(move_sum);
                    end
                end
                ST_ARRIVE: begin
                    if (r_speed == '0 && r_last != '0) begin
                        r_arr <= 1'b1;
                        if (r_err > SAVE_TH || r_err < -SAVE_TH) begin
                            r_saved <= r_pos;
                            r_save  <= 1'b1;
                        end
                    end
                    r_last <= r_speed;
                end
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    r_item <= i_item;
                end
            end
            ST_ERR: begin
                r_err <= {r_goal[POS_W-1], r_goal} - {r_pos[POS_W-1], r_pos};
            end
            ST_ACC: begin
                r_acc     <= (quot < ACC_MIN) ? ACC_MIN : quot;
                r_err_mag <= r_err[32] ? $unsigned(-r_err) : $unsigned(r_err);
            end
            ST_WANT: begin
                // truncate toward zero
                r_want <= trunc_sum[POSITION_FRAC_BITS +: 34];
            end
            ST_CLAMP: begin
                if (r_want > lim_s) begin
                    r_want <= lim_s;
                end else if (r_want < -lim_s) begin
                    r_want <= -lim_s;
                end
            end
            ST_ROUND: begin
                // round half away from zero on the magnitude
                r_q     <= rnd_mag[RND_SH +: 34];
                r_q_neg <= i_prod[PROD_W-1];
            end
            ST_DIFF: begin
                r_err <= {r_pos[POS_W-1], r_pos} - {r_saved[POS_W-1], r_saved};
            end
            default: ;
        endcase
    end

    assign o_res.drive_speed  = r_speed;
    assign o_res.position_now = r_pos;
    assign o_res.target_now   = r_track ? r_goal : r_pos;
    assign o_res.moving       = (r_speed != '0);
    assign o_res.stall_seen   = r_stalled;
    assign o_res.arrived      = r_arr;
    assign o_res.save_request = r_save;

endmodule

// ===== rtl/core/stepper_position_tracker.sv =====
// Stepper position tracker top level: handshakes, output register, sequencer.
// A command steps ST_CMD, ST_DONE; a tick steps ST_STALL, ST_ROUND, ST_MOVE, ST_DIFF,
// ST_ARRIVE, ST_DONE, preceded while tracking a target by ST_ERR, ST_ACC, ST_WANT,
// ST_CLAMP, ST_SLEW, ST_SNAP. One request at a time: o_in_ready returns the cycle
// after the result is handed to the output register. The sequence length is set
// by the single shared multiplier and the compare/add steps.
// Reset (i_rst_n low, synchronous) clears position, speed, target and flags
// and loads the register defaults.
`timescale 1ns / 1ps

module stepper_position_tracker
    import stpt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    t_cfg                     cfg;
    t_mul_op                  mul_op;
    logic signed [PROD_W-1:0] prod;
    logic                     idle;
    logic                     res_valid;
    logic                     res_take;
    t_out_item                res;

    logic                     r_out_valid;
    t_out_item                r_out_data;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = idle;
    assign res_take    = !r_out_valid || i_out_ready;

    stpt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid & o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    stpt_mul u_mul (
        .i_clk  (i_clk),
        .i_op   (mul_op),
        .o_prod (prod)
    );

    stpt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_in_valid & idle),
        .i_item      (i_in_data),
        .i_cfg       (cfg),
        .i_prod      (prod),
        .i_res_take  (res_take),
        .o_idle      (idle),
        .o_mul_op    (mul_op),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_take) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
